[hdl/bpc_pkg.sv]
package bpc_pkg;

  localparam int CFG_W         = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int IDX_W         = 2;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd3000;
  localparam logic [CFG_W-1:0] RESET_RST    = 16'd10000;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [IDX_W-1:0] REG_RESET    = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;
  localparam logic [1:0] EV_RESET = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] reset_ms;
  } cfg_t;

endpackage

[hdl/button_press_classifier_top.sv]
// Channel  Direction  Contents
// in_      request    tdata[0] raw_pressed, one request per millisecond tick
// out_     result     tdata[0] debounced_pressed, tdata[2:1] press_event
// cfg_     write      index 0 debounce_ms, 1 long_ms, 2 reset_ms
//
// The debounce and hold counters and the output register all load at the
// accepting edge, so the result is valid in the following cycle. One request
// per cycle is sustained while out_tready stays high.
// A stalled result holds in_tready low only while out_tready is low.
// rst_n is synchronous and restores the threshold defaults.
module button_press_classifier_top #(
  parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bpc_pkg::IN_TDATA_W-1:0]   in_tdata,  // [0] raw_pressed
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bpc_pkg::OUT_TDATA_W-1:0]  out_tdata, // [0] debounced_pressed,
                                                      // [2:1] press_event
  input  logic                             cfg_we,
  input  logic [bpc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]        cfg_wdata
);
  import bpc_pkg::*;

  cfg_t       cfg_r;
  logic       accept;
  logic       level_nxt;
  logic [1:0] press_event;
  logic       out_valid_r;
  logic       out_level_r;
  logic [1:0] out_event_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.long_ms     <= LONG_RST;
      cfg_r.reset_ms    <= RESET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata;
        REG_LONG:     cfg_r.long_ms     <= cfg_wdata;
        REG_RESET:    cfg_r.reset_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpc_debounce #(.COUNT_BITS(COUNT_BITS)) u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .raw         (in_tdata[0]),
    .debounce_ms (cfg_r.debounce_ms),
    .level_nxt   (level_nxt)
  );

  bpc_classify #(.COUNT_BITS(COUNT_BITS)) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .level       (level_nxt),
    .cfg         (cfg_r),
    .press_event (press_event)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r <= level_nxt;
      out_event_r <= press_event;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_event_r, out_level_r};

endmodule

[hdl/bpc_debounce.sv]
module bpc_debounce #(
  parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       raw,
  input  logic [bpc_pkg::CFG_W-1:0]  debounce_ms,
  output logic                       level_nxt
);
  import bpc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  prev_raw_r, prev_raw_nxt;
  logic [COUNT_BITS-1:0] stable_cnt_r, stable_cnt_nxt;
  logic                  level_r;

  always_comb begin
    prev_raw_nxt   = raw;
    if (raw != prev_raw_r) begin
      stable_cnt_nxt = '0;
    end else if (stable_cnt_r == {COUNT_BITS{1'b1}}) begin
      stable_cnt_nxt = stable_cnt_r;
    end else begin
      stable_cnt_nxt = stable_cnt_r + 1'b1;
    end
    // A threshold above the counter's maximum is never reached.
    if (CMP_W'(stable_cnt_nxt) >= CMP_W'(debounce_ms)) begin
      level_nxt = raw;
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r   <= 1'b0;
      stable_cnt_r <= '0;
      level_r      <= 1'b0;
    end else if (accept) begin
      prev_raw_r   <= prev_raw_nxt;
      stable_cnt_r <= stable_cnt_nxt;
      level_r      <= level_nxt;
    end
  end

endmodule

[hdl/bpc_classify.sv]
module bpc_classify #(
  parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          level,
  input  bpc_pkg::cfg_t cfg,
  output logic [1:0]    press_event
);
  import bpc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  holding_r, holding_nxt;
  logic [COUNT_BITS-1:0] hold_cnt_r, hold_cnt_nxt;
  logic                  long_seen_r, long_seen_nxt;
  logic                  reset_seen_r, reset_seen_nxt;

  always_comb begin
    holding_nxt    = holding_r;
    hold_cnt_nxt   = hold_cnt_r;
    long_seen_nxt  = long_seen_r;
    reset_seen_nxt = reset_seen_r;
    press_event    = EV_NONE;
    if (level) begin
      if (!holding_r) begin
        holding_nxt    = 1'b1;
        hold_cnt_nxt   = '0;
        long_seen_nxt  = 1'b0;
        reset_seen_nxt = 1'b0;
      end else if (hold_cnt_r != {COUNT_BITS{1'b1}}) begin
        hold_cnt_nxt = hold_cnt_r + 1'b1;
      end
      // The reset event wins; a long mark due in the same tick waits a tick.
      if (CMP_W'(hold_cnt_nxt) >= CMP_W'(cfg.reset_ms) && !reset_seen_nxt) begin
        press_event    = EV_RESET;
        reset_seen_nxt = 1'b1;
      end else if (CMP_W'(hold_cnt_nxt) >= CMP_W'(cfg.long_ms) && !long_seen_nxt) begin
        long_seen_nxt = 1'b1;
      end
    end else if (holding_r) begin
      if (!reset_seen_r) begin
        if (long_seen_r) begin
          press_event = EV_LONG;
        end else if (CMP_W'(hold_cnt_r) >= CMP_W'(cfg.debounce_ms)) begin
          press_event = EV_SHORT;
        end
      end
      holding_nxt   = 1'b0;
      hold_cnt_nxt  = '0;
      long_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r    <= 1'b0;
      hold_cnt_r   <= '0;
      long_seen_r  <= 1'b0;
      reset_seen_r <= 1'b0;
    end else if (accept) begin
      holding_r    <= holding_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      long_seen_r  <= long_seen_nxt;
      reset_seen_r <= reset_seen_nxt;
    end
  end

endmodule

[hdl/bpc_checker.sv]
module bpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bpc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bpc_pkg::*;

  // A reset event only fires while the button is held down.
  a_reset_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] == EV_RESET |-> out_tdata[0])
    else $error("reset event with button released");

  // Short and long events are reported on the release tick.
  a_release_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:1] == EV_SHORT || out_tdata[2:1] == EV_LONG)
    |-> !out_tdata[0])
    else $error("press event with button still held");

  // An empty output stage never blocks a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request blocked with empty output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
